[hw/rtl/mta_pkg.sv]
// Shared types, constants and the binomial table for the multipole
// translation accumulator. No dependencies.
`timescale 1ns / 1ps

package mta_pkg;

  localparam int MAX_ORDER = 4;
  localparam int NCOMP     = (MAX_ORDER + 1) * (MAX_ORDER + 2) * (MAX_ORDER + 3) / 6;
  localparam int IDX_W     = $clog2(NCOMP);
  localparam int ACC_W     = 48;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 22;
  localparam int MUL_Y_W   = MUL_A_W + MUL_B_W;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_EMIT  = 1'b1;

  typedef struct packed {
    logic                    wr_en;
    logic                    clr_en;
    logic [IDX_W-1:0]        addr;
    logic signed [ACC_W-1:0] wdata;
  } mem_req_t;

  // C(n,k) for n,k <= MAX_ORDER
  function automatic logic [2:0] binom(input logic [2:0] n, input logic [2:0] k);
    logic [2:0] r;
    r = 3'd0;
    case (n)
      3'd0: if (k == 3'd0) r = 3'd1;
      3'd1: if (k <= 3'd1) r = 3'd1;
      3'd2: begin
        case (k)
          3'd0, 3'd2: r = 3'd1;
          3'd1:       r = 3'd2;
          default:    r = 3'd0;
        endcase
      end
      3'd3: begin
        case (k)
          3'd0, 3'd3: r = 3'd1;
          3'd1, 3'd2: r = 3'd3;
          default:    r = 3'd0;
        endcase
      end
      3'd4: begin
        case (k)
          3'd0, 3'd4: r = 3'd1;
          3'd1, 3'd3: r = 3'd4;
          3'd2:       r = 3'd6;
          default:    r = 3'd0;
        endcase
      end
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/mta_mul.sv]
// Shared unsigned multiplier for the power, weight and moment products.
// Depends on mta_pkg.
`timescale 1ns / 1ps

module mta_mul (
  input  logic [mta_pkg::MUL_A_W-1:0] a,
  input  logic [mta_pkg::MUL_B_W-1:0] b,
  output logic [mta_pkg::MUL_Y_W-1:0] y
);

  assign y = {{mta_pkg::MUL_B_W{1'b0}}, a} * {{mta_pkg::MUL_A_W{1'b0}}, b};

endmodule

[hw/rtl/mta_acc_mem.sv]
// Accumulator store: one write port, one registered read port, per-entry
// valid bits so that reset and emit read back as zero. Depends on mta_pkg.
`timescale 1ns / 1ps

module mta_acc_mem (
  input  logic                            clk,
  input  logic                            rst,
  input  mta_pkg::mem_req_t               req,
  output logic signed [mta_pkg::ACC_W-1:0] rd_data
);

  logic [mta_pkg::ACC_W-1:0] mem [mta_pkg::NCOMP];
  logic [mta_pkg::NCOMP-1:0] valid;
  logic [mta_pkg::ACC_W-1:0] rd_raw;
  logic                      rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    rd_raw <= mem[req.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[req.addr];
      if (req.wr_en) begin
        valid[req.addr] <= 1'b1;
      end else if (req.clr_en) begin
        valid[req.addr] <= 1'b0;
      end
    end
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

[hw/rtl/multipole_translation_accumulator.sv]
// Multipole translation accumulator top level: sequencer over the 35 target
// components around one shared multiplier. Depends on mta_pkg, mta_mul, mta_acc_mem.
`timescale 1ns / 1ps

// Accumulate items walk all 35 target slots. A slot the source does not
// dominate is only checked in S_TGT; a dominated one (a,b,c the order
// differences) takes one setup step, one S_POW step per power step plus one
// that sees the steps done, one for the binomial weight, two for the 36x32
// moment product as two halves on the shared 33x22 multiplier (S_MLO, S_MHI),
// and one read-modify-write of the accumulator. s_tready stays low while an
// accumulate item is walked; a skipped one leaves the sequencer idle. An emit
// item puts out 35 components, each with a memory read, an output load and a
// handshake that waits out the downstream stall, then clears. s_tready is high
// only while the sequencer is idle. The accumulator clears at reset at once.
module multipole_translation_accumulator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [2:0] order_x, [5:3] order_y, [8:6] order_z, [40:9] moment_value,
  // [61:41] disp_x, [82:62] disp_y, [103:83] disp_z, [107:104] site_rank
  input  logic [111:0] s_tdata,
  input  logic         s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  // [2:0] out_order_x, [5:3] out_order_y, [8:6] out_order_z, [56:9] out_moment
  output logic [63:0]  m_tdata,
  output logic         m_tuser,   // saturated
  output logic         m_tlast    // last
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TGT  = 4'd1;
  localparam logic [3:0] S_POW  = 4'd2;
  localparam logic [3:0] S_WGT  = 4'd3;
  localparam logic [3:0] S_MLO  = 4'd4;
  localparam logic [3:0] S_MHI  = 4'd5;
  localparam logic [3:0] S_ADD  = 4'd6;
  localparam logic [3:0] S_ERD  = 4'd7;
  localparam logic [3:0] S_ELD  = 4'd8;
  localparam logic [3:0] S_EWT  = 4'd9;

  localparam int IW = mta_pkg::IDX_W;
  localparam int AW = mta_pkg::ACC_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(mta_pkg::NCOMP - 1);
  localparam logic [3:0]    MAXO     = 4'(mta_pkg::MAX_ORDER);

  logic [3:0]    state;
  logic [IW-1:0] idx;
  logic [2:0]    tt, uu, vv;
  logic [2:0]    tp, up, vp;
  logic [31:0]   qm;
  logic          qneg;
  logic [20:0]   dmx, dmy, dmz;
  logic          dnx, dny, dnz;
  logic [2:0]    ex, ey, ez;
  logic [32:0]   p;
  logic [7:0]    bcoef;
  logic [35:0]   w;
  logic [67:0]   prod;
  logic          neg;
  logic          sat_seen;

  logic [mta_pkg::MUL_A_W-1:0] mul_a;
  logic [mta_pkg::MUL_B_W-1:0] mul_b;
  logic [mta_pkg::MUL_Y_W-1:0] mul_y;

  mta_pkg::mem_req_t       mreq;
  logic signed [AW-1:0]    rd_data;

  mta_mul u_mul (.a(mul_a), .b(mul_b), .y(mul_y));

  mta_acc_mem u_mem (.clk(clk), .rst(rst), .req(mreq), .rd_data(rd_data));

  // input fields
  logic [2:0]        in_ox, in_oy, in_oz;
  logic signed [31:0] in_q;
  logic signed [20:0] in_dx, in_dy, in_dz;
  logic signed [3:0] in_rank;
  logic [4:0]        in_osum;
  logic              in_skip;

  assign in_ox   = s_tdata[2:0];
  assign in_oy   = s_tdata[5:3];
  assign in_oz   = s_tdata[8:6];
  assign in_q    = s_tdata[40:9];
  assign in_dx   = s_tdata[61:41];
  assign in_dy   = s_tdata[82:62];
  assign in_dz   = s_tdata[103:83];
  assign in_rank = s_tdata[107:104];
  assign in_osum = 5'(in_ox) + 5'(in_oy) + 5'(in_oz);
  assign in_skip = in_rank[3] || (in_osum > {1'b0, in_rank}) || (in_osum > 5'(MAXO));

  assign s_tready = (state == S_IDLE);

  // target walk in t,u,v order
  logic [3:0] tuv_sum, tu_sum;
  logic [2:0] tt_next, uu_next, vv_next;
  logic       at_last;

  assign tuv_sum = 4'(tt) + 4'(uu) + 4'(vv);
  assign tu_sum  = 4'(tt) + 4'(uu);
  assign at_last = (idx == LAST_IDX);

  always_comb begin
    tt_next = tt;
    uu_next = uu;
    vv_next = vv;
    if (tuv_sum < MAXO) begin
      vv_next = vv + 3'd1;
    end else if (tu_sum < MAXO) begin
      uu_next = uu + 3'd1;
      vv_next = 3'd0;
    end else begin
      tt_next = tt + 3'd1;
      uu_next = 3'd0;
      vv_next = 3'd0;
    end
  end

  // per-target setup
  logic       dom;
  logic [2:0] da, db, dc;
  logic       neg_tgt;
  logic [7:0] bc_tgt;

  assign dom     = (tt >= tp) && (uu >= up) && (vv >= vp);
  assign da      = tt - tp;
  assign db      = uu - up;
  assign dc      = vv - vp;
  assign neg_tgt = qneg ^ (da[0] & dnx) ^ (db[0] & dny) ^ (dc[0] & dnz);
  assign bc_tgt  = 8'(mta_pkg::binom(tt, tp)) * 8'(mta_pkg::binom(uu, up))
                 * 8'(mta_pkg::binom(vv, vp));

  // shared multiplier operands
  always_comb begin
    mul_a = p;
    mul_b = {1'b0, dmx};
    case (state)
      S_POW: begin
        mul_a = p;
        if (ex != 3'd0)      mul_b = {1'b0, dmx};
        else if (ey != 3'd0) mul_b = {1'b0, dmy};
        else                 mul_b = {1'b0, dmz};
      end
      S_WGT: begin
        mul_a = p;
        mul_b = {14'd0, bcoef};
      end
      S_MLO: begin
        mul_a = {1'b0, qm};
        mul_b = {4'd0, w[17:0]};
      end
      S_MHI: begin
        mul_a = {1'b0, qm};
        mul_b = {4'd0, w[35:18]};
      end
      default: begin
        mul_a = p;
        mul_b = {1'b0, dmx};
      end
    endcase
  end

  // power step with round half up
  logic [mta_pkg::MUL_Y_W-1:0] pow_rnd;
  assign pow_rnd = mul_y + mta_pkg::MUL_Y_W'(32768);

  // contribution and saturating add
  logic [63:0]          rnd64;
  logic [48:0]          cm;
  logic signed [49:0]   sum;
  logic signed [AW-1:0] sum_sat;
  logic                 sum_ovf;

  assign rnd64 = {1'b0, prod[62:0]} + 64'd32768;
  assign cm    = (prod[67:63] != 5'd0) ? {1'b1, 48'd0} : {1'b0, rnd64[63:16]};
  assign sum   = neg ? (50'(rd_data) - $signed({1'b0, cm}))
                     : (50'(rd_data) + $signed({1'b0, cm}));

  always_comb begin
    sum_ovf = 1'b0;
    sum_sat = sum[AW-1:0];
    if (sum > 50'sh0_7FFF_FFFF_FFFF) begin
      sum_ovf = 1'b1;
      sum_sat = {1'b0, {(AW-1){1'b1}}};
    end else if (sum < -50'sh0_8000_0000_0000) begin
      sum_ovf = 1'b1;
      sum_sat = {1'b1, {(AW-1){1'b0}}};
    end
  end

  always_comb begin
    mreq.addr   = idx;
    mreq.wr_en  = (state == S_ADD);
    mreq.clr_en = (state == S_ELD);
    mreq.wdata  = sum_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      tt       <= 3'd0;
      uu       <= 3'd0;
      vv       <= 3'd0;
      sat_seen <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            idx <= '0;
            tt  <= 3'd0;
            uu  <= 3'd0;
            vv  <= 3'd0;
            if (s_tuser == mta_pkg::CMD_EMIT) begin
              state <= S_ERD;
            end else if (!in_skip) begin
              state <= S_TGT;
            end
          end
        end
        S_TGT: begin
          if (dom) begin
            state <= S_POW;
          end else if (at_last) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + IW'(1);
            tt  <= tt_next;
            uu  <= uu_next;
            vv  <= vv_next;
          end
        end
        S_POW: begin
          if (ex == 3'd0 && ey == 3'd0 && ez == 3'd0) begin
            state <= S_WGT;
          end
        end
        S_WGT: state <= S_MLO;
        S_MLO: state <= S_MHI;
        S_MHI: state <= S_ADD;
        S_ADD: begin
          if (sum_ovf) begin
            sat_seen <= 1'b1;
          end
          if (at_last) begin
            state <= S_IDLE;
          end else begin
            state <= S_TGT;
            idx   <= idx + IW'(1);
            tt    <= tt_next;
            uu    <= uu_next;
            vv    <= vv_next;
          end
        end
        S_ERD: state <= S_ELD;
        S_ELD: begin
          m_tvalid <= 1'b1;
          state    <= S_EWT;
        end
        S_EWT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (at_last) begin
              sat_seen <= 1'b0;
              state    <= S_IDLE;
            end else begin
              state <= S_ERD;
              idx   <= idx + IW'(1);
              tt    <= tt_next;
              uu    <= uu_next;
              vv    <= vv_next;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        tp   <= in_ox;
        up   <= in_oy;
        vp   <= in_oz;
        qneg <= in_q[31];
        qm   <= in_q[31] ? (32'd0 - 32'(in_q)) : 32'(in_q);
        dnx  <= in_dx[20];
        dny  <= in_dy[20];
        dnz  <= in_dz[20];
        dmx  <= in_dx[20] ? (21'd0 - 21'(in_dx)) : 21'(in_dx);
        dmy  <= in_dy[20] ? (21'd0 - 21'(in_dy)) : 21'(in_dy);
        dmz  <= in_dz[20] ? (21'd0 - 21'(in_dz)) : 21'(in_dz);
      end
      S_TGT: begin
        ex    <= da;
        ey    <= db;
        ez    <= dc;
        p     <= 33'd65536;
        neg   <= neg_tgt;
        bcoef <= bc_tgt;
      end
      S_POW: begin
        // p stays within 2^32 at this order, so the cap never engages
        if (ex != 3'd0) begin
          p  <= pow_rnd[48:16];
          ex <= ex - 3'd1;
        end else if (ey != 3'd0) begin
          p  <= pow_rnd[48:16];
          ey <= ey - 3'd1;
        end else if (ez != 3'd0) begin
          p  <= pow_rnd[48:16];
          ez <= ez - 3'd1;
        end
      end
      S_WGT: w    <= mul_y[35:0];
      S_MLO: prod <= {13'd0, mul_y};
      S_MHI: prod <= prod + {mul_y[49:0], 18'd0};
      S_ELD: begin
        m_tdata <= {7'd0, rd_data, vv, uu, tt};
        m_tuser <= sat_seen;
        m_tlast <= at_last;
      end
      default: ;
    endcase
  end

endmodule

[verif/tb.sv]
// Self-checking testbench for multipole_translation_accumulator: random and
// directed accumulate/emit items against a bit-exact scoreboard predictor.
// Depends on mta_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 3000;
  localparam int NUM_RANDOM  = 290;

  // Scoreboard: shadow copy of the moment accumulator plus expected components
  class moment_scoreboard;
    longint          acc_shadow[35];
    bit              sat_shadow;
    logic [65:0]     expected_components[$];
    int              errors;
    int unsigned     pascal[5][5] = '{'{1, 0, 0, 0, 0}, '{1, 1, 0, 0, 0}, '{1, 2, 1, 0, 0},
                                      '{1, 3, 3, 1, 0}, '{1, 4, 6, 4, 1}};

    function new();
      foreach (acc_shadow[i]) acc_shadow[i] = 0;
      sat_shadow = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Q.16 power product, rounded to nearest per step, capped at 2^42
    function longint unsigned power_steps(longint unsigned p, longint unsigned m, int n);
      for (int i = 0; i < n; i++) begin
        p = (p * m + 64'd32768) >> 16;
        if (p > (64'd1 << 42)) p = 64'd1 << 42;
      end
      return p;
    endfunction

    function void note_input(bit cmd, logic [111:0] d);
      int idx, tp, up, vp, a, b, c;
      longint q, dx, dy, dz, rank, s;
      longint unsigned qm, p, w, wh, wl, prod, cm;
      bit neg;
      idx = 0;
      if (cmd == mta_pkg::CMD_EMIT) begin
        for (int t = 0; t <= 4; t++)
          for (int u = 0; u <= 4 - t; u++)
            for (int v = 0; v <= 4 - t - u; v++) begin
              expected_components.insert(expected_components.size(),
                                         {idx == 34, sat_shadow, 7'd0,
                                          acc_shadow[idx][47:0],
                                          3'(v), 3'(u), 3'(t)});
              acc_shadow[idx] = 0;
              idx++;
            end
        sat_shadow = 0;
        return;
      end
      tp = d[2:0];
      up = d[5:3];
      vp = d[8:6];
      q    = longint'($signed(d[40:9]));
      dx   = longint'($signed(d[61:41]));
      dy   = longint'($signed(d[82:62]));
      dz   = longint'($signed(d[103:83]));
      rank = longint'($signed(d[107:104]));
      qm = (q < 0) ? -q : q;
      if (rank < 0 || tp + up + vp > rank || tp + up + vp > 4) return;
      for (int t = 0; t <= 4; t++)
        for (int u = 0; u <= 4 - t; u++)
          for (int v = 0; v <= 4 - t - u; v++) begin
            if (t >= tp && u >= up && v >= vp) begin
              a = t - tp;
              b = u - up;
              c = v - vp;
              p = power_steps(64'd65536, (dx < 0) ? -dx : dx, a);
              p = power_steps(p, (dy < 0) ? -dy : dy, b);
              p = power_steps(p, (dz < 0) ? -dz : dz, c);
              w = longint'(pascal[t][tp]) * pascal[u][up] * pascal[v][vp] * p;
              neg = (q < 0) ^ (a[0] && dx < 0) ^ (b[0] && dy < 0) ^ (c[0] && dz < 0);
              wh = w >> 32;
              wl = w & 64'hFFFF_FFFF;
              if (wh * qm >= (64'd1 << 31)) begin
                cm = 64'd1 << 48;
              end else begin
                prod = wl * qm + ((wh * qm) << 32);
                if (prod[63]) cm = 64'd1 << 48;
                else cm = (prod + 64'd32768) >> 16;
              end
              s = acc_shadow[idx] + (neg ? -longint'(cm) : longint'(cm));
              if (s > 64'sd140737488355327) begin
                s = 64'sd140737488355327;
                sat_shadow = 1;
              end
              if (s < -64'sd140737488355328) begin
                s = -64'sd140737488355328;
                sat_shadow = 1;
              end
              acc_shadow[idx] = s;
            end
            idx++;
          end
    endfunction

    task check_result(logic [63:0] d, logic user, logic last);
      logic [65:0] e;
      if (expected_components.size() == 0) begin
        report($sformatf("unexpected component tdata=%h", d));
        return;
      end
      e = expected_components.pop_front();
      if (d[8:0] !== e[8:0])
        report($sformatf("order got %h exp %h", d[8:0], e[8:0]));
      if (d[56:9] !== e[56:9])
        report($sformatf("moment (%h) got %h exp %h", e[8:0], d[56:9], e[56:9]));
      if (d[63:57] !== e[63:57])
        report($sformatf("pad bits got %h", d[63:57]));
      if (user !== e[64])
        report($sformatf("saturated (%h) got %b exp %b", e[8:0], user, e[64]));
      if (last !== e[65])
        report($sformatf("last (%h) got %b exp %b", e[8:0], last, e[65]));
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [111:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  moment_scoreboard sb;
  bit  idle_on;
  bit  hold_go;
  int  cycles;

  multipole_translation_accumulator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 16) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [111:0] pack_accum(int tp, int up, int vp, logic [31:0] q,
                                              logic [20:0] dx, logic [20:0] dy,
                                              logic [20:0] dz, logic [3:0] rank);
    return {4'd0, rank, dz, dy, dx, q, 3'(vp), 3'(up), 3'(tp)};
  endfunction

  function automatic logic [20:0] rand_disp();
    case ($urandom_range(0, 3))
      0: return 21'($urandom);
      1: return 21'($signed($urandom_range(0, 262143)) - 131072);
      2: return 21'($signed($urandom_range(0, 2047)) - 1024);
      default: return $urandom_range(0, 1) ? 21'h0F_FFFF : 21'h10_0000;
    endcase
  endfunction

  task automatic send_item(bit cmd, logic [111:0] d);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    sb.note_input(cmd, d);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_emit();
    send_item(mta_pkg::CMD_EMIT, 112'({$urandom, $urandom, $urandom, $urandom}));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_components.size() != 0);
  endtask

  initial begin
    int tp, up, vp, sum;
    logic [31:0] q;
    sb = new();
    cycles = 0;
    idle_on = 1;
    hold_go = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= mta_pkg::CMD_ACCUM;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: fresh emit, extremes, skips, oversized contribution
    send_emit();
    send_item(mta_pkg::CMD_ACCUM, pack_accum(0, 0, 0, 32'h0001_0000, 21'h01_0000,
                                             21'h1F_0000, 21'h00_8000, 4'd4));
    send_item(mta_pkg::CMD_ACCUM, pack_accum(1, 1, 0, 32'h8000_0000, 21'h10_0000,
                                             21'h0F_FFFF, 21'h10_0000, 4'd2));
    send_item(mta_pkg::CMD_ACCUM, pack_accum(0, 0, 1, 32'h7FFF_FFFF, 21'h1F_FFFF,
                                             21'h00_0001, 21'h10_0000, 4'd7));
    send_item(mta_pkg::CMD_ACCUM, pack_accum(4, 0, 0, 32'hFFFF_FFFF, 21'h0, 21'h0, 21'h0,
                                             4'd4));
    send_item(mta_pkg::CMD_ACCUM, pack_accum(0, 0, 4, 32'h0000_0001, 21'h0, 21'h0, 21'h0,
                                             4'd4));
    send_item(mta_pkg::CMD_ACCUM, pack_accum(0, 0, 0, 32'h1234_5678, 21'h0F_FFFF, 21'h0,
                                             21'h0, 4'hF));
    send_item(mta_pkg::CMD_ACCUM, pack_accum(0, 0, 0, 32'h1234_5678, 21'h0F_FFFF, 21'h0,
                                             21'h0, 4'h8));
    send_item(mta_pkg::CMD_ACCUM, pack_accum(2, 1, 0, 32'h1234_5678, 21'h0F_FFFF, 21'h0,
                                             21'h0, 4'd2));
    send_item(mta_pkg::CMD_ACCUM, pack_accum(7, 7, 7, 32'h1234_5678, 21'h0F_FFFF, 21'h0,
                                             21'h0, 4'd7));
    send_item(mta_pkg::CMD_ACCUM, pack_accum(5, 0, 0, 32'h1234_5678, 21'h0F_FFFF, 21'h0,
                                             21'h0, 4'd7));
    send_emit();
    // full-scale sources: for the fourth-order targets W*|q| reaches 2^63 and those targets saturate
    send_item(mta_pkg::CMD_ACCUM, pack_accum(0, 0, 0, 32'h7FFF_FFFF, 21'h0F_FFFF,
                                             21'h0F_FFFF, 21'h0F_FFFF, 4'd4));
    send_item(mta_pkg::CMD_ACCUM, pack_accum(0, 0, 0, 32'h8000_0000, 21'h10_0000,
                                             21'h10_0000, 21'h10_0000, 4'd4));
    send_item(mta_pkg::CMD_ACCUM, pack_accum(0, 0, 0, 32'h8000_0000, 21'h10_0000,
                                             21'h10_0000, 21'h10_0000, 4'd4));
    send_emit();
    send_emit();

    // sender pause until everything has drained
    drain();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 60) begin
        // receiver blocks while items keep coming
        hold_go = 1;
        send_emit();
      end
      if (n == 150) drain();
      if (n == NUM_RANDOM - 50) idle_on = 0;
      if ($urandom_range(0, 9) == 0) begin
        send_emit();
      end else if ($urandom_range(0, 6) == 0) begin
        send_item(mta_pkg::CMD_ACCUM, 112'({$urandom, $urandom, $urandom, $urandom}));
      end else begin
        do begin
          tp = $urandom_range(0, 4);
          up = $urandom_range(0, 4);
          vp = $urandom_range(0, 4);
          sum = tp + up + vp;
        end while (sum > 4);
        q = $urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 1 << 20)) -
                                                  (1 << 19));
        send_item(mta_pkg::CMD_ACCUM, pack_accum(tp, up, vp, q, rand_disp(), rand_disp(),
                                                 rand_disp(),
                                                 4'($urandom_range(sum, 4))));
      end
    end
    send_emit();

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/mta_pkg.sv
hw/rtl/mta_mul.sv
hw/rtl/mta_acc_mem.sv
hw/rtl/multipole_translation_accumulator.sv
verif/tb.sv
